FILE: design/l53rt_pkg.sv
// Shared types for the 5/3 lifting row transform.
`default_nettype none

package l53rt_pkg;

  typedef enum logic {
    DIR_FWD = 1'b0,
    DIR_INV = 1'b1
  } dir_t;

  typedef struct packed {
    logic holding;
    logic row_start;
  } flags_t;

  typedef struct packed {
    logic [1:0] n_res;
    logic       r0_last;
    logic       load_held;
    logic       load_prior;
  } lift_ctl_t;

endpackage

`default_nettype wire

FILE: design/l53rt_core.sv
// Combinational lifting datapath: results and next state for one sample pair.
`default_nettype none

module l53rt_core
  import l53rt_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  dir_t                    dir,
  input  logic [SAMPLE_BITS-1:0]  a,
  input  logic [SAMPLE_BITS-1:0]  b,
  input  logic                    row_end,
  input  logic [SAMPLE_BITS-1:0]  held_first,
  input  logic [SAMPLE_BITS-1:0]  held_second,
  input  logic [SAMPLE_BITS-1:0]  prior_odd,
  input  flags_t                  flags,
  output logic [SAMPLE_BITS-1:0]  r0_first,
  output logic [SAMPLE_BITS-1:0]  r0_second,
  output logic [SAMPLE_BITS-1:0]  r1_first,
  output logic [SAMPLE_BITS-1:0]  r1_second,
  output logic [SAMPLE_BITS-1:0]  held_first_nxt,
  output logic [SAMPLE_BITS-1:0]  prior_odd_nxt,
  output flags_t                  flags_nxt,
  output lift_ctl_t               ctl
);

  localparam int W = SAMPLE_BITS;
  localparam int E = SAMPLE_BITS + 2;

  logic signed [E-1:0] ae, be, hoe, poe, pre;
  logic signed [E-1:0] f_sum_pb, f_h_full, f_lo_full, f_l_full, he;
  logic signed [E-1:0] i_odd1_full, i_even1_full, i_odd2_full, i_even2_full;
  logic signed [E-1:0] o1e, o2e;
  logic [W-1:0] f_h, f_lo, f_l, i_odd1, i_even1, i_odd2, i_even2;

  assign ae  = E'(signed'(a));
  assign be  = E'(signed'(b));
  assign hoe = E'(signed'(held_first));
  assign poe = E'(signed'(held_second));
  assign pre = E'(signed'(prior_odd));

  // forward
  assign f_sum_pb  = poe + be;
  assign f_h_full  = flags.holding ? (ae - (f_sum_pb >>> 1)) : (ae - be);
  assign f_h       = f_h_full[W-1:0];
  assign he        = E'(signed'(f_h));
  assign f_lo_full = poe + ((hoe + he + E'(2)) >>> 2);
  assign f_lo      = f_lo_full[W-1:0];
  assign f_l_full  = be + ((he + E'(1)) >>> 3);
  assign f_l       = f_l_full[W-1:0];

  // inverse
  assign i_odd1_full  = poe - ((hoe + ae + E'(2)) >>> 2);
  assign i_odd1       = i_odd1_full[W-1:0];
  assign o1e          = E'(signed'(i_odd1));
  assign i_even1_full = flags.row_start ? (hoe + o1e) : (hoe + ((pre + o1e) >>> 1));
  assign i_even1      = i_even1_full[W-1:0];
  assign i_odd2_full  = be - ((ae + E'(1)) >>> 3);
  assign i_odd2       = i_odd2_full[W-1:0];
  assign o2e          = E'(signed'(i_odd2));
  assign i_even2_full = flags.holding ? (ae + ((o1e + o2e) >>> 1)) : (ae + o2e);
  assign i_even2      = i_even2_full[W-1:0];

  logic [W-1:0] p0_first, p0_second, pe_first, pe_second;

  always_comb begin
    if (dir == DIR_FWD) begin
      p0_first  = held_first;
      p0_second = f_lo;
      pe_first  = f_h;
      pe_second = f_l;
      held_first_nxt = f_h;
      prior_odd_nxt  = prior_odd;
    end else begin
      p0_first  = i_even1;
      p0_second = i_odd1;
      pe_first  = i_even2;
      pe_second = i_odd2;
      held_first_nxt = a;
      prior_odd_nxt  = row_end ? i_odd2 : i_odd1;
    end
  end

  assign r0_first  = flags.holding ? p0_first : pe_first;
  assign r0_second = flags.holding ? p0_second : pe_second;
  assign r1_first  = pe_first;
  assign r1_second = pe_second;

  assign flags_nxt.holding   = !row_end;
  assign flags_nxt.row_start = row_end ? 1'b1 : !flags.holding;

  assign ctl.n_res      = 2'(flags.holding) + 2'(row_end);
  assign ctl.r0_last    = !flags.holding;
  assign ctl.load_held  = !row_end;
  assign ctl.load_prior = (dir == DIR_INV) && (flags.holding || row_end);

endmodule

`default_nettype wire

FILE: design/lifting_53_row_transform_unit.sv
// Top level of the 5/3 integer lifting row transform with its result queue.
//
// Usage: configure direction through cfg_wr_en/cfg_wr_data (0 forward,
// 1 inverse) between rows. Sample pairs enter on the in_ valid/ready
// channel, one transaction per cycle while in_ready is high; in_row_end
// marks the last pair of a row. Results leave on the out_ valid/ready
// channel with out_last_out on the row's final pair. A pair is held until
// the next pair arrives, so the first pair of a row yields nothing and the
// row-end pair yields two results. A result is written into the result
// queue by the transaction that causes it. Sustained rate is one pair per
// cycle while the receiver keeps up; the row-end pair's two results leave
// one after the other through a four-entry result queue, and in_ready drops
// whenever the queue has fewer than two free entries, so a stalled receiver
// back-pressures the input after at most four further pairs. Reset (rst_n low,
// synchronous) empties the queue, selects forward and clears all held state.
`default_nettype none

module lifting_53_row_transform_unit
  import l53rt_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_first_in,
  input  logic [SAMPLE_BITS-1:0] in_second_in,
  input  logic                   in_row_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_first_out,
  output logic [SAMPLE_BITS-1:0] out_second_out,
  output logic                   out_last_out
);

  localparam int W = SAMPLE_BITS;
  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  dir_t         dir_r;
  logic [W-1:0] held_first_r, held_second_r, prior_odd_r;
  flags_t       flags_r;

  logic [W-1:0] r0_first, r0_second, r1_first, r1_second;
  logic [W-1:0] held_first_nxt, prior_odd_nxt;
  flags_t       flags_nxt;
  lift_ctl_t    ctl;

  l53rt_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .dir            (dir_r),
    .a              (in_first_in),
    .b              (in_second_in),
    .row_end        (in_row_end),
    .held_first     (held_first_r),
    .held_second    (held_second_r),
    .prior_odd      (prior_odd_r),
    .flags          (flags_r),
    .r0_first       (r0_first),
    .r0_second      (r0_second),
    .r1_first       (r1_first),
    .r1_second      (r1_second),
    .held_first_nxt (held_first_nxt),
    .prior_odd_nxt  (prior_odd_nxt),
    .flags_nxt      (flags_nxt),
    .ctl            (ctl)
  );

  logic in_xfer, out_xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r         <= DIR_FWD;
      held_first_r  <= '0;
      held_second_r <= '0;
      prior_odd_r   <= '0;
      flags_r       <= '{holding: 1'b0, row_start: 1'b1};
    end else begin
      if (cfg_wr_en) begin
        dir_r <= dir_t'(cfg_wr_data);
      end
      if (in_xfer) begin
        flags_r <= flags_nxt;
        if (ctl.load_held) begin
          held_first_r  <= held_first_nxt;
          held_second_r <= in_second_in;
        end
        if (ctl.load_prior) begin
          prior_odd_r <= prior_odd_nxt;
        end
      end
    end
  end

  // result queue
  logic [W-1:0]  q_first_r  [DEPTH];
  logic [W-1:0]  q_second_r [DEPTH];
  logic          q_last_r   [DEPTH];
  logic [AW-1:0] wp_r, rp_r, wp1;
  logic [AW:0]   count_r, count_nxt;
  logic [1:0]    n_wr;

  assign in_ready  = count_r <= (AW+1)'(DEPTH - 2);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = count_r != '0;
  assign out_xfer  = out_valid && out_ready;
  assign n_wr      = in_xfer ? ctl.n_res : 2'd0;
  assign wp1       = wp_r + AW'(1);
  assign count_nxt = count_r + (AW+1)'(n_wr) - (AW+1)'(out_xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_r + AW'(n_wr);
      rp_r    <= rp_r + AW'(out_xfer);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      q_first_r[wp_r]  <= r0_first;
      q_second_r[wp_r] <= r0_second;
      q_last_r[wp_r]   <= ctl.r0_last;
    end
    if (n_wr == 2'd2) begin
      q_first_r[wp1]  <= r1_first;
      q_second_r[wp1] <= r1_second;
      q_last_r[wp1]   <= 1'b1;
    end
  end

  assign out_first_out  = q_first_r[rp_r];
  assign out_second_out = q_second_r[rp_r];
  assign out_last_out   = q_last_r[rp_r];

endmodule

`default_nettype wire
